// File: rtl/core/gauge_needle_reading_defines.svh
// Assertion macros for the gauge needle reading block.
// Used by the front and back modules; no other dependencies.
`ifndef GAUGE_NEEDLE_READING_DEFINES_SVH
`define GAUGE_NEEDLE_READING_DEFINES_SVH
`ifndef SYNTHESIS
`define GNR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`else
`define GNR_ASSERT(label, clk, rst_n, prop)
`endif
`endif

// File: rtl/core/gnr_pkg.sv
// Shared types and constants for the gauge needle reading block.
// No dependencies.
package gnr_pkg;

    localparam int CoordBits = 12;
    localparam int FracBits = 8;
    localparam int AngleBits = 17;
    localparam int ValueBits = 24;
    localparam int CordicSteps = 24;
    localparam int AccBits = 34;
    localparam int CwBits = 40;

    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_RADIUS = 3'd2;
    localparam logic [2:0] REG_ANGLE_MIN = 3'd3;
    localparam logic [2:0] REG_ANGLE_MAX = 3'd4;
    localparam logic [2:0] REG_VALUE_MIN = 3'd5;
    localparam logic [2:0] REG_VALUE_MAX = 3'd6;

    // One frame end handed from the front to the back.
    typedef struct packed {
        logic               found;
        logic signed [12:0] dx;
        logic signed [12:0] dy;
    } frame_t;

    // Arctangent table, degrees in Q24.
    function automatic logic [AccBits-1:0] atan_q24(input logic [4:0] i);
        case (i)
            5'd0: atan_q24 = 34'd754974720;
            5'd1: atan_q24 = 34'd445687602;
            5'd2: atan_q24 = 34'd235489088;
            5'd3: atan_q24 = 34'd119537938;
            5'd4: atan_q24 = 34'd60000934;
            5'd5: atan_q24 = 34'd30029717;
            5'd6: atan_q24 = 34'd15018523;
            5'd7: atan_q24 = 34'd7509720;
            5'd8: atan_q24 = 34'd3754917;
            5'd9: atan_q24 = 34'd1877466;
            5'd10: atan_q24 = 34'd938734;
            5'd11: atan_q24 = 34'd469367;
            5'd12: atan_q24 = 34'd234684;
            5'd13: atan_q24 = 34'd117342;
            5'd14: atan_q24 = 34'd58671;
            5'd15: atan_q24 = 34'd29335;
            5'd16: atan_q24 = 34'd14668;
            5'd17: atan_q24 = 34'd7334;
            5'd18: atan_q24 = 34'd3667;
            5'd19: atan_q24 = 34'd1833;
            5'd20: atan_q24 = 34'd917;
            5'd21: atan_q24 = 34'd458;
            5'd22: atan_q24 = 34'd229;
            5'd23: atan_q24 = 34'd115;
            default: atan_q24 = '0;
        endcase
    endfunction

endpackage

// File: rtl/core/gnr_front.sv
// Front part: ring test on each segment and latching of the needle vector.
// Depends on gnr_pkg and the assertion macro header.
`include "gauge_needle_reading_defines.svh"
module gnr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [11:0]          sx,
    input  logic [11:0]          sy,
    input  logic [11:0]          ex,
    input  logic [11:0]          ey,
    input  logic                 last,
    input  logic [11:0]          cx,
    input  logic [11:0]          cy,
    input  logic [11:0]          radius,
    output logic                 q_valid,
    input  logic                 q_take,
    output gnr_pkg::frame_t      q_data
);

    logic                 match_reg, match_next;
    logic signed [12:0]   ndx_reg, ndy_reg, ndx_next, ndy_next;
    logic                 q_valid_reg;
    gnr_pkg::frame_t      q_data_reg;

    logic signed [12:0] dsx, dsy, dex, dey;
    logic [11:0]        asx, asy, aex, aey;
    logic [23:0]        qsx, qsy, qex, qey;
    logic [25:0]        ds, de, nearer, farther;
    logic [23:0]        r2;
    logic               hit, accept;

    assign in_stall = q_valid_reg;
    assign accept = in_valid && !in_stall;

    // Distances from the center, squared.
    always_comb
    begin
        dsx = $signed({1'b0, sx}) - $signed({1'b0, cx});
        dsy = $signed({1'b0, sy}) - $signed({1'b0, cy});
        dex = $signed({1'b0, ex}) - $signed({1'b0, cx});
        dey = $signed({1'b0, ey}) - $signed({1'b0, cy});
        asx = dsx[12] ? 12'(-dsx) : dsx[11:0];
        asy = dsy[12] ? 12'(-dsy) : dsy[11:0];
        aex = dex[12] ? 12'(-dex) : dex[11:0];
        aey = dey[12] ? 12'(-dey) : dey[11:0];
        qsx = {12'd0, asx} * {12'd0, asx};
        qsy = {12'd0, asy} * {12'd0, asy};
        qex = {12'd0, aex} * {12'd0, aex};
        qey = {12'd0, aey} * {12'd0, aey};
        ds = {2'd0, qsx} + {2'd0, qsy};
        de = {2'd0, qex} + {2'd0, qey};
        nearer = (ds < de) ? ds : de;
        farther = (ds < de) ? de : ds;
        r2 = {12'd0, radius} * {12'd0, radius};
        hit = ({nearer, 4'd0} < {6'd0, r2})
            && (35'(nearer) * 35'd400 > 35'(r2) * 35'd9)
            && (farther < {2'd0, r2})
            && ({farther, 2'd0} > {4'd0, r2});
    end

    // Latch the first matching segment of the frame.
    always_comb
    begin
        match_next = match_reg;
        ndx_next = ndx_reg;
        ndy_next = ndy_reg;
        if (accept)
        begin
            if (last)
            begin
                match_next = 1'b0;
                ndx_next = '0;
                ndy_next = '0;
            end
            else if (!match_reg && hit)
            begin
                match_next = 1'b1;
                ndx_next = (ds > de) ? dsx : dex;
                ndy_next = (ds > de) ? -dsy : -dey;
            end
        end
    end

    // Frame-end queue entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            ndx_reg <= '0;
            ndy_reg <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            ndx_reg <= ndx_next;
            ndy_reg <= ndy_next;
            if (accept && last)
                q_valid_reg <= 1'b1;
            else if (q_take)
                q_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            if (!match_reg && hit)
            begin
                q_data_reg.found <= 1'b1;
                q_data_reg.dx <= (ds > de) ? dsx : dex;
                q_data_reg.dy <= (ds > de) ? -dsy : -dey;
            end
            else
            begin
                q_data_reg.found <= match_reg;
                q_data_reg.dx <= ndx_reg;
                q_data_reg.dy <= ndy_reg;
            end
        end
    end

    assign q_valid = q_valid_reg;
    assign q_data = q_data_reg;

    `GNR_ASSERT(a_frame_clears, clk, rst_n, (accept && last) |=> !match_reg)
    `GNR_ASSERT(a_full_stalls, clk, rst_n, q_valid_reg |-> in_stall)
    `GNR_ASSERT(a_nomatch_zero, clk, rst_n, !match_reg |-> (ndx_reg == 13'sd0))

endmodule

// File: rtl/core/gnr_back.sv
// Back part: CORDIC arctangent, quadrant mapping and reading scale.
// Depends on gnr_pkg and the assertion macro header.
`include "gauge_needle_reading_defines.svh"
module gnr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_take,
    input  gnr_pkg::frame_t      q_data,
    input  logic [16:0]          angle_min,
    input  logic [16:0]          angle_max,
    input  logic signed [23:0]   value_min,
    input  logic signed [23:0]   value_max,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 needle_found,
    output logic                 range_error,
    output logic [16:0]          needle_angle,
    output logic signed [23:0]   reading
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_CORD = 7'b0000010,
        ST_ANG  = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] cnt_reg;
    logic signed [39:0] x_reg, y_reg;
    logic signed [35:0] acc_reg;
    logic found_reg, dxneg_reg, same_reg, axis_reg;
    logic [16:0] angle_reg;
    logic signed [43:0] p_reg;
    logic [43:0] num_reg;
    logic [43:0] rem_reg;
    logic [44:0] quo_reg;
    logic [17:0] den_reg;
    logic neg_reg, rerr_reg;
    logic signed [23:0] reading_reg;

    logic signed [12:0] adx, ady;
    logic signed [39:0] xs, ys;
    logic [35:0] rnd;
    logic [16:0] a;
    logic signed [17:0] span;
    logic signed [24:0] vspan;
    logic [44:0] two_num;
    logic [45:0] trial;
    logic signed [46:0] rd;

    assign q_take = q_valid && (state_reg == ST_IDLE);
    assign span = $signed({1'b0, angle_max}) - $signed({1'b0, angle_min});
    assign vspan = 25'(value_max) - 25'(value_min);
    assign xs = x_reg >>> cnt_reg[4:0];
    assign ys = y_reg >>> cnt_reg[4:0];
    assign adx = q_data.dx[12] ? -q_data.dx : q_data.dx;
    assign ady = q_data.dy[12] ? -q_data.dy : q_data.dy;
    assign rnd = (acc_reg[35] ? 36'd0 : unsigned'(acc_reg)) + 36'd32768;
    assign a = rnd[32:16];
    assign two_num = {num_reg, 1'b0} + 45'(den_reg);
    assign trial = {1'b0, rem_reg, quo_reg[44]} - {27'd0, den_reg, 1'b0};
    assign rd = (neg_reg ? -47'(quo_reg) : 47'(quo_reg)) + 47'(value_min);

    // Sequencer: CORDIC steps, angle mapping, one multiply, then one quotient bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // The divider spends two setup steps, then produces 45 quotient bits.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_CORD;
            ST_CORD: if (axis_reg || cnt_reg == 6'(gnr_pkg::CordicSteps - 1))
                state_next = ST_ANG;
            ST_ANG:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 6'd46) state_next = ST_FIN;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (!out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cnt_reg <= '0;
                found_reg <= q_data.found;
                dxneg_reg <= q_data.dx[12];
                same_reg <= (q_data.dx[12] == q_data.dy[12]);
                axis_reg <= (q_data.dx == 13'sd0) || (q_data.dy == 13'sd0);
                x_reg <= 40'(adx) <<< 24;
                y_reg <= 40'(ady) <<< 24;
                acc_reg <= '0;
            end
            ST_CORD:
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (!y_reg[39])
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    acc_reg <= acc_reg + 36'(gnr_pkg::atan_q24(cnt_reg[4:0]));
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    acc_reg <= acc_reg - 36'(gnr_pkg::atan_q24(cnt_reg[4:0]));
                end
            end
            ST_ANG:
            begin
                if (axis_reg || !found_reg)
                    angle_reg <= '0;
                else if (same_reg)
                    angle_reg <= (dxneg_reg ? 17'd23040 : 17'd69120) - a;
                else
                    angle_reg <= (dxneg_reg ? 17'd23040 : 17'd69120) + a;
            end
            ST_MUL:
            begin
                p_reg <= 44'($signed({1'b0, angle_reg}) - $signed({1'b0, angle_min}))
                    * 44'(vspan);
                rerr_reg <= found_reg && (span == 18'sd0);
                cnt_reg <= '0;
            end
            // Restoring division of (2num+den) by 2den, one bit a cycle.
            ST_DIV:
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    num_reg <= p_reg[43] ? 44'(-p_reg) : 44'(p_reg);
                    den_reg <= span[17] ? 18'(-span) : 18'(span);
                    neg_reg <= p_reg[43] != span[17];
                end
                else if (cnt_reg == 6'd1)
                begin
                    rem_reg <= '0;
                    quo_reg <= two_num;
                end
                else
                begin
                    if (!trial[45])
                        rem_reg <= trial[43:0];
                    else
                        rem_reg <= {rem_reg[42:0], quo_reg[44]};
                    quo_reg <= {quo_reg[43:0], !trial[45]};
                end
            end
            ST_FIN:
            begin
                if (!found_reg || rerr_reg)
                    reading_reg <= '0;
                else if (rd < -47'sd8388608)
                    reading_reg <= 24'h800000;
                else if (rd > 47'sd8388607)
                    reading_reg <= 24'h7fffff;
                else
                    reading_reg <= rd[23:0];
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = (state_reg == ST_OUT);
    assign needle_found = found_reg;
    assign range_error = rerr_reg;
    assign needle_angle = angle_reg;
    assign reading = reading_reg;

    `GNR_ASSERT(a_take_idle, clk, rst_n, q_take |-> (state_reg == ST_IDLE))
    `GNR_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid)
    `GNR_ASSERT(a_onehot, clk, rst_n, $onehot(state_reg))

endmodule

// File: rtl/core/gauge_needle_reading.sv
// Top level of the gauge needle reading block with its register file.
// Depends on gnr_pkg, gnr_front and gnr_back.
// Segments are accepted one per cycle while no frame end waits; a frame end
// occupies the back part, also while the output stalls, through 24 CORDIC
// steps, the angle mapping, one multiply, the divider with its two setup steps,
// the saturation and the output beat (a frame with no usable vector skips
// all but one CORDIC step), during which one further frame end can be queued.
module gauge_needle_reading (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [11:0]        seg_start_x,
    input  logic [11:0]        seg_start_y,
    input  logic [11:0]        seg_end_x,
    input  logic [11:0]        seg_end_y,
    input  logic               last_segment,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               needle_found,
    output logic               range_error,
    output logic [16:0]        needle_angle,
    output logic signed [23:0] reading
);

    logic [11:0] cx_reg, cy_reg, rad_reg;
    logic [16:0] amin_reg, amax_reg;
    logic signed [23:0] vmin_reg, vmax_reg;
    logic q_valid, q_take;
    gnr_pkg::frame_t q_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            rad_reg <= 12'd1;
            amin_reg <= '0;
            amax_reg <= 17'd92160;
            vmin_reg <= '0;
            vmax_reg <= 24'sd25600;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gnr_pkg::REG_CENTER_X: cx_reg <= cfg_data[11:0];
                gnr_pkg::REG_CENTER_Y: cy_reg <= cfg_data[11:0];
                gnr_pkg::REG_RADIUS: rad_reg <= cfg_data[11:0];
                gnr_pkg::REG_ANGLE_MIN: amin_reg <= cfg_data[16:0];
                gnr_pkg::REG_ANGLE_MAX: amax_reg <= cfg_data[16:0];
                gnr_pkg::REG_VALUE_MIN: vmin_reg <= cfg_data;
                gnr_pkg::REG_VALUE_MAX: vmax_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    gnr_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .sx(seg_start_x), .sy(seg_start_y), .ex(seg_end_x), .ey(seg_end_y),
        .last(last_segment), .cx(cx_reg), .cy(cy_reg), .radius(rad_reg),
        .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
    );

    gnr_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
        .q_data(q_data), .angle_min(amin_reg), .angle_max(amax_reg),
        .value_min(vmin_reg), .value_max(vmax_reg), .out_valid(out_valid),
        .out_stall(out_stall), .needle_found(needle_found),
        .range_error(range_error), .needle_angle(needle_angle), .reading(reading)
    );

endmodule
